@@ hw/rtl/pchmb_pkg.sv @@
package pchmb_pkg;

	localparam int CHANNELS         = 16;
	localparam int HITS_PER_CHANNEL = 16;
	localparam int MAX_OUT          = 16;

	localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int HIT_W   = (HITS_PER_CHANNEL > 1) ? $clog2(HITS_PER_CHANNEL) : 1;
	localparam int LEN_W   = HIT_W + 1;
	localparam int ADDR_W  = CH_W + HIT_W;
	localparam int DEPTH   = CHANNELS * (1 << HIT_W);
	localparam int LIMIT_W = 5;

	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 96;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [19:0] WINDOW_RST    = 20'd25000;
	localparam logic [31:0] THRESHOLD_RST = 32'd10000;
	localparam logic [4:0]  HITS_OUT_RST  = 5'd16;

	localparam logic KIND_DEPOSIT = 1'b0;
	localparam logic KIND_READOUT = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MERGE_WINDOW = 2'd0,
		CFG_THRESHOLD    = 2'd1,
		CFG_HITS_OUT     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] time_ps;
		logic [31:0] energy_ev;
		logic [15:0] track;
		logic [7:0]  particle;
	} hit_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		hit_t              data;
	} ram_wr_t;

endpackage

@@ hw/rtl/pchmb_hitram.sv @@
module pchmb_hitram (
	input  logic                         clk,
	input  pchmb_pkg::ram_wr_t           wr,
	input  logic [pchmb_pkg::ADDR_W-1:0] rd_addr,
	output pchmb_pkg::hit_t              rd_data
);

	pchmb_pkg::hit_t mem [pchmb_pkg::DEPTH];
	pchmb_pkg::hit_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

@@ hw/rtl/per_channel_hit_merge_buffer.sv @@
// one request at a time; the input is ready only while the sequencer is idle
// deposit: accept, then scan stored hits, move each later hit up one place and write
// the new hit; scanned plus moved is at most HITS_PER_CHANNEL; a merge ends the scan
// readout: scan stored hits, then push the last result; both can wait while the output is stalled
// the single read and write port of the hit memory sets this order of steps
// reset restores register defaults and clears list lengths and overflow marks, not hit memory
module per_channel_hit_merge_buffer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// channel, time_ps, energy_ev, track_number, particle_code, zero pad
	input  logic [pchmb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// kind
	input  logic                                 s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// out_channel, hit_time_ps, hit_energy_ev, hit_track, hit_particle, overflowed, zero pad
	output logic [pchmb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// hit_valid
	output logic                                 m_axis_tuser,
	output logic                                 m_axis_tlast,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pchmb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pchmb_pkg::CFG_DATA_W-1:0]     cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_SHIFT  = 6'b000100,
		ST_INSERT = 6'b001000,
		ST_RSCAN  = 6'b010000,
		ST_RLAST  = 6'b100000
	} state_t;

	localparam int CH_W    = pchmb_pkg::CH_W;
	localparam int HIT_W   = pchmb_pkg::HIT_W;
	localparam int LEN_W   = pchmb_pkg::LEN_W;
	localparam int LIMIT_W = pchmb_pkg::LIMIT_W;

	// input fields
	logic [3:0]      in_ch;
	pchmb_pkg::hit_t in_hit;
	logic [CH_W-1:0] in_ch_idx;
	logic            in_ch_ok;

	assign in_ch           = s_axis_tdata[3:0];
	assign in_hit.time_ps  = s_axis_tdata[35:4];
	assign in_hit.energy_ev = s_axis_tdata[67:36];
	assign in_hit.track    = s_axis_tdata[83:68];
	assign in_hit.particle = s_axis_tdata[91:84];
	assign in_ch_idx       = CH_W'(in_ch);
	assign in_ch_ok        = 32'(in_ch) < 32'(pchmb_pkg::CHANNELS);

	// configuration
	logic [19:0]        window_q;
	logic [31:0]        threshold_q;
	logic [4:0]         hits_out_q;
	logic [LIMIT_W-1:0] limit_cfg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= pchmb_pkg::WINDOW_RST;
			threshold_q <= pchmb_pkg::THRESHOLD_RST;
			hits_out_q  <= pchmb_pkg::HITS_OUT_RST;
		end else if (cfg_valid) begin
			case (pchmb_pkg::cfg_reg_t'(cfg_index))
				pchmb_pkg::CFG_MERGE_WINDOW: window_q    <= cfg_data[19:0];
				pchmb_pkg::CFG_THRESHOLD:    threshold_q <= cfg_data[31:0];
				pchmb_pkg::CFG_HITS_OUT:     hits_out_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (hits_out_q == 5'd0) begin
			limit_cfg = LIMIT_W'(1);
		end else if (32'(hits_out_q) > 32'(pchmb_pkg::MAX_OUT)) begin
			limit_cfg = LIMIT_W'(pchmb_pkg::MAX_OUT);
		end else begin
			limit_cfg = LIMIT_W'(hits_out_q);
		end
	end

	// sequencer state
	state_t             state_q, state_d;
	logic [3:0]         ch_q, ch_d;
	logic               ch_ok_q, ch_ok_d;
	pchmb_pkg::hit_t    new_q, new_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [LEN_W-1:0]   pos_q, pos_d;
	logic [LEN_W-1:0]   leff_q, leff_d;
	logic [HIT_W-1:0]   idx_q, idx_d;
	logic [HIT_W-1:0]   j_q, j_d;
	logic               ovf_q, ovf_d;
	logic [LIMIT_W-1:0] limit_q, limit_d;
	logic [LIMIT_W-1:0] cnt_q, cnt_d;
	pchmb_pkg::hit_t    pend_q, pend_d;
	logic               pend_v_q, pend_v_d;

	logic [LEN_W-1:0] lengths_q [pchmb_pkg::CHANNELS];
	logic             marks_q   [pchmb_pkg::CHANNELS];

	logic [CH_W-1:0]  ch_idx;
	logic [HIT_W-1:0] rd_idx;
	logic [CH_W-1:0]  rd_ch;
	pchmb_pkg::ram_wr_t ram_wr;
	pchmb_pkg::hit_t  rd_hit;

	logic             len_we;
	logic [LEN_W-1:0] len_wdata;
	logic             mark_set;
	logic             chan_clear;

	// output register
	logic            out_v_q;
	logic [3:0]      out_ch_q;
	logic            out_hv_q;
	pchmb_pkg::hit_t out_hit_q;
	logic            out_ovf_q;
	logic            out_last_q;
	logic            out_free;
	logic            push;
	logic            push_hv;
	pchmb_pkg::hit_t push_hit;
	logic            push_last;

	assign ch_idx   = CH_W'(ch_q);
	assign out_free = !out_v_q || m_axis_tready;

	// shared compare and add unit
	logic        later;
	logic [31:0] diff;
	logic        merge;
	logic [32:0] sum;
	logic        at_end;
	logic        qual;

	assign later  = rd_hit.time_ps > new_q.time_ps;
	assign diff   = later ? (rd_hit.time_ps - new_q.time_ps) : (new_q.time_ps - rd_hit.time_ps);
	assign merge  = diff < {12'd0, window_q};
	assign sum    = {1'b0, rd_hit.energy_ev} + {1'b0, new_q.energy_ev};
	assign at_end = ({1'b0, idx_q} + LEN_W'(1)) == len_q;
	assign qual   = rd_hit.energy_ev > threshold_q;

	always_comb begin
		logic [LEN_W-1:0] place;
		state_d    = state_q;
		ch_d       = ch_q;
		ch_ok_d    = ch_ok_q;
		new_d      = new_q;
		len_d      = len_q;
		pos_d      = pos_q;
		leff_d     = leff_q;
		idx_d      = idx_q;
		j_d        = j_q;
		ovf_d      = ovf_q;
		limit_d    = limit_q;
		cnt_d      = cnt_q;
		pend_d     = pend_q;
		pend_v_d   = pend_v_q;
		rd_ch      = ch_idx;
		rd_idx     = idx_q;
		ram_wr     = '0;
		len_we     = 1'b0;
		len_wdata  = leff_q + LEN_W'(1);
		mark_set   = 1'b0;
		chan_clear = 1'b0;
		push       = 1'b0;
		push_hv    = 1'b0;
		push_hit   = '0;
		push_last  = 1'b0;
		place      = later ? {1'b0, idx_q} : len_q;

		case (state_q)
			ST_IDLE: begin
				rd_ch  = in_ch_idx;
				rd_idx = '0;
				if (s_axis_tvalid) begin
					ch_d    = in_ch;
					ch_ok_d = in_ch_ok;
					new_d   = in_hit;
					idx_d   = '0;
					len_d   = lengths_q[in_ch_idx];
					if (s_axis_tuser == pchmb_pkg::KIND_READOUT) begin
						ovf_d    = in_ch_ok ? marks_q[in_ch_idx] : 1'b0;
						limit_d  = limit_cfg;
						cnt_d    = '0;
						pend_v_d = 1'b0;
						if (!in_ch_ok || lengths_q[in_ch_idx] == '0) begin
							state_d = ST_RLAST;
						end else begin
							state_d = ST_RSCAN;
						end
					end else if (in_ch_ok && in_hit.energy_ev != 32'd0) begin
						if (lengths_q[in_ch_idx] == '0) begin
							pos_d   = '0;
							leff_d  = '0;
							state_d = ST_INSERT;
						end else begin
							state_d = ST_SCAN;
						end
					end
				end
			end
			ST_SCAN: begin
				if (merge) begin
					ram_wr.en             = 1'b1;
					ram_wr.addr           = {ch_idx, idx_q};
					ram_wr.data           = rd_hit;
					ram_wr.data.energy_ev = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					if (later) begin
						ram_wr.data.time_ps = new_q.time_ps;
					end
					state_d = ST_IDLE;
				end else if (later || at_end) begin
					pos_d = place;
					if (32'(len_q) == pchmb_pkg::HITS_PER_CHANNEL) begin
						mark_set = 1'b1;
						leff_d   = LEN_W'(pchmb_pkg::HITS_PER_CHANNEL - 1);
					end else begin
						leff_d   = len_q;
					end
					if (32'(place) == pchmb_pkg::HITS_PER_CHANNEL) begin
						// later than every hit of a full list: dropped
						state_d = ST_IDLE;
					end else if (leff_d == place) begin
						state_d = ST_INSERT;
					end else begin
						j_d     = leff_d[HIT_W-1:0];
						rd_idx  = leff_d[HIT_W-1:0] - HIT_W'(1);
						state_d = ST_SHIFT;
					end
				end else begin
					idx_d  = idx_q + HIT_W'(1);
					rd_idx = idx_q + HIT_W'(1);
				end
			end
			ST_SHIFT: begin
				// move entry j-1 up to j, newest first
				ram_wr.en   = 1'b1;
				ram_wr.addr = {ch_idx, j_q};
				ram_wr.data = rd_hit;
				if ({1'b0, j_q} == pos_q + LEN_W'(1)) begin
					state_d = ST_INSERT;
				end else begin
					j_d    = j_q - HIT_W'(1);
					rd_idx = j_q - HIT_W'(2);
				end
			end
			ST_INSERT: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = {ch_idx, pos_q[HIT_W-1:0]};
				ram_wr.data = new_q;
				len_we      = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_RSCAN: begin
				if (qual && pend_v_q && !out_free) begin
					rd_idx = idx_q;
				end else begin
					if (qual) begin
						if (pend_v_q) begin
							push     = 1'b1;
							push_hv  = 1'b1;
							push_hit = pend_q;
						end
						pend_d   = rd_hit;
						pend_v_d = 1'b1;
						cnt_d    = cnt_q + LIMIT_W'(1);
					end
					if (at_end || (qual && cnt_q + LIMIT_W'(1) == limit_q)) begin
						state_d = ST_RLAST;
					end else begin
						idx_d  = idx_q + HIT_W'(1);
						rd_idx = idx_q + HIT_W'(1);
					end
				end
			end
			ST_RLAST: begin
				if (out_free) begin
					push       = 1'b1;
					push_hv    = pend_v_q;
					push_hit   = pend_v_q ? pend_q : '0;
					push_last  = 1'b1;
					chan_clear = ch_ok_q;
					pend_v_d   = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pend_v_q <= 1'b0;
			for (int c = 0; c < pchmb_pkg::CHANNELS; c++) begin
				lengths_q[c] <= '0;
				marks_q[c]   <= 1'b0;
			end
		end else begin
			state_q  <= state_d;
			pend_v_q <= pend_v_d;
			if (len_we) begin
				lengths_q[ch_idx] <= len_wdata;
			end
			if (mark_set) begin
				marks_q[ch_idx] <= 1'b1;
			end
			if (chan_clear) begin
				lengths_q[ch_idx] <= '0;
				marks_q[ch_idx]   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ch_q    <= ch_d;
		ch_ok_q <= ch_ok_d;
		new_q   <= new_d;
		len_q   <= len_d;
		pos_q   <= pos_d;
		leff_q  <= leff_d;
		idx_q   <= idx_d;
		j_q     <= j_d;
		ovf_q   <= ovf_d;
		limit_q <= limit_d;
		cnt_q   <= cnt_d;
		pend_q  <= pend_d;
	end

	pchmb_hitram u_hitram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_addr ({rd_ch, rd_idx}),
		.rd_data (rd_hit)
	);

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_ch_q   <= ch_q;
			out_hv_q   <= push_hv;
			out_hit_q  <= push_hit;
			out_ovf_q  <= ovf_q;
			out_last_q <= push_last;
		end
	end

	assign s_axis_tready = state_q == ST_IDLE;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = out_hv_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {3'd0, out_ovf_q, out_hit_q.particle, out_hit_q.track,
		out_hit_q.energy_ev, out_hit_q.time_ps, out_ch_q};

endmodule

@@ test/per_channel_hit_merge_buffer_test.sv @@
`timescale 1ns / 100ps

module per_channel_hit_merge_buffer_test;

	localparam logic [pchmb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int SEGMENT_ITEMS = 60;
	localparam int SETTLE_CYCLES = 60;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int LONG_HOLD     = 400;

	typedef struct packed {
		logic [pchmb_pkg::CH_W-1:0] channel;
		logic                       has_hit;
		pchmb_pkg::hit_t            hit;
		logic                       ovf;
		logic                       is_last;
	} readout_t;

	class hit_merge_scoreboard;
		pchmb_pkg::hit_t lists[pchmb_pkg::CHANNELS][pchmb_pkg::HITS_PER_CHANNEL];
		int unsigned     fill[pchmb_pkg::CHANNELS];
		bit              dropped[pchmb_pkg::CHANNELS];
		logic [19:0]     window;
		logic [31:0]     threshold;
		logic [4:0]      hits_out;
		readout_t        readout_q[$];
		int unsigned     errors;

		function new();
			window = pchmb_pkg::WINDOW_RST;
			threshold = pchmb_pkg::THRESHOLD_RST;
			hits_out = pchmb_pkg::HITS_OUT_RST;
			errors = 0;
			foreach (fill[c]) begin
				fill[c] = 0;
				dropped[c] = 1'b0;
			end
		endfunction

		function int pending();
			return readout_q.size();
		endfunction

		function void set_reg(logic [pchmb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
			case (pchmb_pkg::cfg_reg_t'(idx))
				pchmb_pkg::CFG_MERGE_WINDOW: window = value[19:0];
				pchmb_pkg::CFG_THRESHOLD: threshold = value;
				pchmb_pkg::CFG_HITS_OUT: hits_out = value[4:0];
				default: ;
			endcase
		endfunction

		function void merge_deposit(int ch, pchmb_pkg::hit_t dep);
			int          i;
			int          j;
			int          len;
			logic [31:0] ht;
			logic [31:0] diff;
			logic [32:0] sum;

			len = fill[ch];
			for (i = 0; i < len; i++) begin
				ht = lists[ch][i].time_ps;
				diff = (ht > dep.time_ps) ? ht - dep.time_ps : dep.time_ps - ht;
				if (diff < {12'd0, window}) begin
					sum = {1'b0, lists[ch][i].energy_ev} + {1'b0, dep.energy_ev};
					lists[ch][i].energy_ev = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					if (ht > dep.time_ps)
						lists[ch][i].time_ps = dep.time_ps;
					return;
				end
				if (ht > dep.time_ps)
					break;
			end
			if (len == pchmb_pkg::HITS_PER_CHANNEL) begin
				dropped[ch] = 1'b1;
				// new hit is later than every stored one: it is the one dropped
				if (i >= pchmb_pkg::HITS_PER_CHANNEL)
					return;
				len = pchmb_pkg::HITS_PER_CHANNEL - 1;
			end
			for (j = len; j > i; j--)
				lists[ch][j] = lists[ch][j - 1];
			lists[ch][i] = dep;
			fill[ch] = len + 1;
		endfunction

		function void drain_channel(int ch);
			int       limit;
			int       n;
			readout_t r;

			limit = (hits_out == 0) ? 1 :
				(hits_out > pchmb_pkg::MAX_OUT) ? pchmb_pkg::MAX_OUT : int'(hits_out);
			n = 0;
			for (int i = 0; i < fill[ch] && n < limit; i++) begin
				if (lists[ch][i].energy_ev > threshold) begin
					r.channel = ch[pchmb_pkg::CH_W-1:0];
					r.has_hit = 1'b1;
					r.hit = lists[ch][i];
					r.ovf = dropped[ch];
					r.is_last = 1'b0;
					readout_q.push_back(r);
					n++;
				end
			end
			if (n == 0) begin
				r = '0;
				r.channel = ch[pchmb_pkg::CH_W-1:0];
				r.ovf = dropped[ch];
				readout_q.push_back(r);
			end
			readout_q[readout_q.size() - 1].is_last = 1'b1;
			fill[ch] = 0;
			dropped[ch] = 1'b0;
		endfunction

		function void note_request(logic kind, logic [pchmb_pkg::IN_DATA_W-1:0] data);
			pchmb_pkg::hit_t dep;
			int              ch;

			ch = int'(data[3:0]);
			dep.time_ps = data[35:4];
			dep.energy_ev = data[67:36];
			dep.track = data[83:68];
			dep.particle = data[91:84];
			if (kind == pchmb_pkg::KIND_READOUT)
				drain_channel(ch);
			else if (dep.energy_ev != 0)
				merge_deposit(ch, dep);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [pchmb_pkg::OUT_DATA_W-1:0] data, logic valid,
				logic last);
			readout_t want;

			if (readout_q.size() == 0) begin
				$display("%0t: expected no result, got data %h valid %b last %b",
					$time, data, valid, last);
				errors++;
				return;
			end
			want = readout_q.pop_front();
			compare_field("out_channel", want.channel, data[3:0]);
			compare_field("hit_valid", want.has_hit, valid);
			compare_field("hit_time_ps", want.hit.time_ps, data[35:4]);
			compare_field("hit_energy_ev", want.hit.energy_ev, data[67:36]);
			compare_field("hit_track", want.hit.track, data[83:68]);
			compare_field("hit_particle", want.hit.particle, data[91:84]);
			compare_field("overflowed", want.ovf, data[92]);
			compare_field("last_of_run", want.is_last, last);
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [pchmb_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                             s_axis_tuser = 1'b0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [pchmb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                             m_axis_tuser;
	logic                             m_axis_tlast;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [pchmb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [pchmb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int tx_idle_pct = 6;
	int rx_stall_pct = 65;
	bit hold_req = 1'b0;
	int hold_left = 0;

	hit_merge_scoreboard sb = new();

	per_channel_hit_merge_buffer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side: check accepted hits, then pick tready for the next cycle
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic send_item(input logic kind, input logic [3:0] ch, input logic [31:0] t,
			input logic [31:0] e, input logic [15:0] trk, input logic [7:0] pc);
		int gap;
		logic [pchmb_pkg::IN_DATA_W-1:0] data;

		gap = 0;
		data = {4'd0, pc, trk, e, t, ch};
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= data;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(kind, data);
	endtask

	task automatic write_reg(input logic [pchmb_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, value);
	endtask

	task automatic configure(input logic [31:0] win, input logic [31:0] thr,
			input logic [31:0] hits);
		write_reg(CFG_UNUSED, $urandom());
		write_reg(pchmb_pkg::CFG_MERGE_WINDOW, win);
		write_reg(pchmb_pkg::CFG_THRESHOLD, thr);
		write_reg(pchmb_pkg::CFG_HITS_OUT, hits);
		cfg_valid <= 1'b0;
	endtask

	// stop offering requests and wait for every expected hit to come out
	task automatic drain();
		int waited;

		waited = 0;
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
	endtask

	// bursts of deposits around one time on one channel, then a readout of it
	task automatic run_segment(input int target);
		int          done;
		int          n;
		logic [3:0]  ch;
		logic [31:0] base;
		logic [31:0] span;
		logic [31:0] e;

		done = 0;
		while (done < target) begin
			ch = 4'($urandom_range(15));
			base = $urandom();
			span = 4 * sb.window + 2000;
			n = ($urandom_range(3) == 0) ? $urandom_range(17, 24) : $urandom_range(0, 10);
			for (int k = 0; k < n; k++) begin
				case ($urandom_range(15))
					0: e = 32'd0;
					1: e = $urandom_range(32'hFFFF_FFFF, 32'hF000_0000);
					default: e = $urandom_range(40000, 1);
				endcase
				// stray deposit on a random channel, which may be the same one
				if ($urandom_range(9) == 0)
					send_item(pchmb_pkg::KIND_DEPOSIT, 4'($urandom_range(15)),
						base + $urandom_range(span), e,
						16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)));
				else
					send_item(pchmb_pkg::KIND_DEPOSIT, ch, base + $urandom_range(span), e,
						16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)));
				if (e != 0)
					done++;
			end
			send_item(pchmb_pkg::KIND_READOUT, ch, $urandom(), $urandom(),
				16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)));
			done++;
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, window 25000, threshold 10000, 16 hits out
		send_item(pchmb_pkg::KIND_READOUT, 4'd0, 32'd0, 32'd0, 16'd0, 8'd0);
		send_item(pchmb_pkg::KIND_DEPOSIT, 4'd1, 32'd1000, 32'd0, 16'h1234, 8'h12);
		send_item(pchmb_pkg::KIND_DEPOSIT, 4'd1, 32'd100000, 32'd20000, 16'hFFFF, 8'hFF);
		// merges into the hit above, saturates and takes the earlier time
		send_item(pchmb_pkg::KIND_DEPOSIT, 4'd1, 32'd90000, 32'hFFFF_FFFF, 16'd1, 8'd1);
		send_item(pchmb_pkg::KIND_DEPOSIT, 4'd1, 32'd0, 32'd5000, 16'd2, 8'd2);
		send_item(pchmb_pkg::KIND_DEPOSIT, 4'd1, 32'hFFFF_FFFF, 32'd50000, 16'd0, 8'd0);
		send_item(pchmb_pkg::KIND_READOUT, 4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
			8'hFF);
		for (int k = 1; k <= pchmb_pkg::HITS_PER_CHANNEL; k++)
			send_item(pchmb_pkg::KIND_DEPOSIT, 4'd15, k * 100000, 20000 + k, 16'(k), 8'(k));
		// full list: early hit pushes out the latest, late hit is dropped itself
		send_item(pchmb_pkg::KIND_DEPOSIT, 4'd15, 32'd50000, 32'd30000, 16'hAAAA, 8'h55);
		send_item(pchmb_pkg::KIND_DEPOSIT, 4'd15, 32'd4000000000, 32'd30000, 16'h5555,
			8'hAA);
		send_item(pchmb_pkg::KIND_READOUT, 4'd15, 32'd0, 32'd0, 16'd0, 8'd0);

		for (int seg = 0; seg < 6; seg++) begin
			drain();
			repeat (SETTLE_CYCLES) @(posedge clk);
			tx_idle_pct = (seg < 2) ? 6 : (seg < 4) ? 65 : 0;
			rx_stall_pct = (seg < 2) ? 65 : (seg < 4) ? 6 : 0;
			case (seg)
				0: configure(32'd25000, 32'd10000, 32'd16);
				1: configure(32'd0, 32'd0, 32'd0);
				2: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				3: configure($urandom_range(200000, 1), $urandom_range(50000),
					$urandom_range(16, 1));
				4: configure(32'd1, 32'd1, 32'd17);
				default: configure($urandom_range(100000), $urandom_range(40000),
					$urandom_range(31));
			endcase
			if (seg == 1) begin
				run_segment(SEGMENT_ITEMS / 2);
				drain();
				run_segment(SEGMENT_ITEMS / 2);
			end else begin
				// long output stall with the sender still pushing requests
				if (seg == 4)
					hold_req = 1'b1;
				run_segment(SEGMENT_ITEMS);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0t: %0d expected results never arrived", $time, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#4000000;
		$display("%0t: timeout", $time);
		$display("Mismatches found");
		$finish;
	end

endmodule
